// ===== hw/rtl/mpenc_pkg.sv =====
`default_nettype none
package mpenc_pkg;

	typedef enum logic [3:0] {
		FN_UINT  = 4'd0,
		FN_INT   = 4'd1,
		FN_BOOL  = 4'd2,
		FN_NIL   = 4'd3,
		FN_FLT32 = 4'd4,
		FN_ARR   = 4'd5,
		FN_MAP   = 4'd6,
		FN_STR   = 4'd7,
		FN_BIN   = 4'd8,
		FN_RAW   = 4'd9
	} func_t;

	typedef logic [7:0] mp_byte_t;

	localparam mp_byte_t MP_NIL    = 8'hc0;
	localparam mp_byte_t MP_FALSE  = 8'hc2;
	localparam mp_byte_t MP_TRUE   = 8'hc3;
	localparam mp_byte_t MP_BIN8   = 8'hc4;
	localparam mp_byte_t MP_BIN16  = 8'hc5;
	localparam mp_byte_t MP_BIN32  = 8'hc6;
	localparam mp_byte_t MP_FLT32  = 8'hca;
	localparam mp_byte_t MP_UINT8  = 8'hcc;
	localparam mp_byte_t MP_UINT16 = 8'hcd;
	localparam mp_byte_t MP_UINT32 = 8'hce;
	localparam mp_byte_t MP_UINT64 = 8'hcf;
	localparam mp_byte_t MP_INT8   = 8'hd0;
	localparam mp_byte_t MP_INT16  = 8'hd1;
	localparam mp_byte_t MP_INT32  = 8'hd2;
	localparam mp_byte_t MP_INT64  = 8'hd3;
	localparam mp_byte_t MP_STR8   = 8'hd9;
	localparam mp_byte_t MP_STR16  = 8'hda;
	localparam mp_byte_t MP_STR32  = 8'hdb;
	localparam mp_byte_t MP_ARR16  = 8'hdc;
	localparam mp_byte_t MP_ARR32  = 8'hdd;
	localparam mp_byte_t MP_MAP16  = 8'hde;
	localparam mp_byte_t MP_MAP32  = 8'hdf;
	localparam mp_byte_t MP_FIXARR = 8'h90;
	localparam mp_byte_t MP_FIXMAP = 8'h80;
	localparam mp_byte_t MP_FIXSTR = 8'ha0;

	// largest encoding: prefix plus eight data bytes
	localparam int MaxBytes = 9;

endpackage
`default_nettype wire

// ===== hw/rtl/mpenc_if.sv =====
`default_nettype none
interface mpenc_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	logic [63:0] value;

	modport source (output valid, func, value, input ready);
	modport sink   (input valid, func, value, output ready);
	modport mon    (input valid, ready, func, value);
endinterface

interface mpenc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
	modport mon    (input valid, ready, out_byte, last);
endinterface
`default_nettype wire

// ===== hw/rtl/msgpack_value_encoder.sv =====
// an accepted request beat is registered in the input stage, then encoded into the shifter
// throughput: one byte per cycle absent back-pressure, set by the single byte-wide shifter
// n-byte requests (1 to 9) hold the shifter until their last byte leaves; one-byte requests
// flow at one per cycle absent back-pressure; the next request is encoded during the drain
// reset: arst_n low clears the input stage valid and the shifter byte count at once
`default_nettype none
module msgpack_value_encoder (
	input  wire          clk,
	input  wire          arst_n,
	mpenc_req_if.sink    req,
	mpenc_byte_if.source rsp
);
	import mpenc_pkg::*;

	localparam int BufW = 8 * MaxBytes;
	localparam int CntW = $clog2(MaxBytes + 1);

	logic            valid_s1;
	logic [3:0]      func_s1;
	logic [63:0]     value_s1;

	logic [BufW-1:0] shift_s2;
	logic [CntW-1:0] cnt_s2;

	logic            s2_free;
	logic            out_beat;

	mp_byte_t        enc_hdr;
	logic [CntW-1:0] enc_nb;
	logic [CntW-1:0] enc_cnt;
	logic [63:0]     enc_data;
	logic [BufW-1:0] enc_buf;

	assign out_beat  = rsp.valid && rsp.ready;
	assign s2_free   = (cnt_s2 == '0) || ((cnt_s2 == CntW'(1)) && rsp.ready);
	assign req.ready = !valid_s1 || s2_free;

	assign rsp.valid    = cnt_s2 != '0;
	assign rsp.out_byte = shift_s2[BufW-1 -: 8];
	assign rsp.last     = cnt_s2 == CntW'(1);

	// shortest-form encoder: one prefix byte plus 0, 1, 2, 4 or 8 data bytes
	always_comb begin
		logic        fix_ok;
		logic        has8;
		mp_byte_t    fix_base;
		mp_byte_t    c8;
		mp_byte_t    c16;
		mp_byte_t    c32;
		logic        is_hdr;
		logic [63:0] v;

		v        = value_s1;
		enc_hdr  = v[7:0];
		enc_nb   = '0;
		enc_cnt  = CntW'(1);
		fix_ok   = 1'b0;
		has8     = 1'b0;
		fix_base = '0;
		c8       = '0;
		c16      = '0;
		c32      = '0;
		is_hdr   = 1'b0;

		case (func_s1)
			FN_UINT, FN_INT: begin
				if (!v[63] || func_s1 == FN_UINT) begin
					if (v[63:7] == '0) begin
						enc_hdr = v[7:0];
					end else if (v[63:8] == '0) begin
						enc_hdr = MP_UINT8;
						enc_nb  = CntW'(1);
					end else if (v[63:16] == '0) begin
						enc_hdr = MP_UINT16;
						enc_nb  = CntW'(2);
					end else if (v[63:32] == '0) begin
						enc_hdr = MP_UINT32;
						enc_nb  = CntW'(4);
					end else begin
						enc_hdr = MP_UINT64;
						enc_nb  = CntW'(8);
					end
				end else begin
					if (&v[63:5]) begin
						enc_hdr = v[7:0];
					end else if (&v[63:7]) begin
						enc_hdr = MP_INT8;
						enc_nb  = CntW'(1);
					end else if (&v[63:15]) begin
						enc_hdr = MP_INT16;
						enc_nb  = CntW'(2);
					end else if (&v[63:31]) begin
						enc_hdr = MP_INT32;
						enc_nb  = CntW'(4);
					end else begin
						enc_hdr = MP_INT64;
						enc_nb  = CntW'(8);
					end
				end
			end
			FN_BOOL:  enc_hdr = (v != '0) ? MP_TRUE : MP_FALSE;
			FN_NIL:   enc_hdr = MP_NIL;
			FN_FLT32: begin
				enc_hdr = MP_FLT32;
				enc_nb  = CntW'(4);
			end
			FN_ARR: begin
				is_hdr   = 1'b1;
				fix_ok   = v[63:4] == '0;
				fix_base = MP_FIXARR;
				c16      = MP_ARR16;
				c32      = MP_ARR32;
			end
			FN_MAP: begin
				is_hdr   = 1'b1;
				fix_ok   = v[63:4] == '0;
				fix_base = MP_FIXMAP;
				c16      = MP_MAP16;
				c32      = MP_MAP32;
			end
			FN_STR: begin
				is_hdr   = 1'b1;
				fix_ok   = v[63:5] == '0;
				fix_base = MP_FIXSTR;
				has8     = 1'b1;
				c8       = MP_STR8;
				c16      = MP_STR16;
				c32      = MP_STR32;
			end
			FN_BIN: begin
				is_hdr = 1'b1;
				has8   = 1'b1;
				c8     = MP_BIN8;
				c16    = MP_BIN16;
				c32    = MP_BIN32;
			end
			FN_RAW:   enc_hdr = v[7:0];
			default:  enc_cnt = '0;
		endcase

		if (is_hdr) begin
			if (fix_ok) begin
				enc_hdr = fix_base | v[7:0];
			end else if (has8 && v[63:8] == '0) begin
				enc_hdr = c8;
				enc_nb  = CntW'(1);
			end else if (v[63:16] == '0) begin
				enc_hdr = c16;
				enc_nb  = CntW'(2);
			end else begin
				// oversized lengths keep only their low 32 bits
				enc_hdr = c32;
				enc_nb  = CntW'(4);
			end
		end

		if (enc_cnt != '0) begin
			enc_cnt = enc_nb + CntW'(1);
		end

		// left-align the data bytes behind the prefix
		case (enc_nb)
			CntW'(1): enc_data = {v[7:0], 56'h0};
			CntW'(2): enc_data = {v[15:0], 48'h0};
			CntW'(4): enc_data = {v[31:0], 32'h0};
			default:  enc_data = v;
		endcase

		enc_buf = {enc_hdr, enc_data};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1  <= req.func;
			value_s1 <= req.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (s2_free) begin
			cnt_s2 <= valid_s1 ? enc_cnt : '0;
		end else if (out_beat) begin
			cnt_s2 <= cnt_s2 - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			shift_s2 <= enc_buf;
		end else if (out_beat) begin
			shift_s2 <= {shift_s2[BufW-9:0], 8'h00};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mpenc_chk.sv =====
`default_nettype none
module mpenc_chk (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	input  wire       req_ready,
	input  wire       rsp_valid,
	input  wire       rsp_ready,
	input  wire [7:0] rsp_out_byte,
	input  wire       rsp_last
);

	// a stalled output beat holds its byte and marker
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
		else $error("output beat changed while stalled");

	// the bytes of one item are offered back to back with rsp_valid held high between them
	a_item_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
		else $error("gap inside a multi-byte item");

	// back-pressure on the request side only while the output holds a byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("request stalled with empty output");

	// an empty output with an empty input stage never stalls the next request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && !$past(req_valid && req_ready) |-> req_ready)
		else $error("request stalled while block empty");

endmodule

bind msgpack_value_encoder mpenc_chk u_mpenc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_out_byte (rsp.out_byte),
	.rsp_last     (rsp.last)
);
`default_nettype wire
